FILE: rtl/core/rgblz_pkg.sv
// ----------------------------------------------------------------------------
// rgblz_pkg: shared types and constants of the RGB pixel LZ decoder
// Parse phases, register indexes, status codes and the history pipe entry.
// ----------------------------------------------------------------------------
package rgblz_pkg;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_HISTORY_DEPTH = 8192;

    localparam logic [7:0] LIT_EXT_CODE = 8'h7F;
    localparam logic [7:0] COPY_FLAG    = 8'h80;
    localparam logic [4:0] SEL_MASK     = 5'h1F;
    localparam logic [16:0] LIT_EXT_BASE = 17'h80;
    localparam logic [16:0] CPY_EXT_BASE = 17'd4;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_CLEN  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EARLY = 2'd1;
    localparam logic [1:0] ST_STOP  = 2'd2;

    typedef enum logic [7:0] {
        PH_FIRST   = 8'b0000_0001,
        PH_CONTROL = 8'b0000_0010,
        PH_LIT_LO  = 8'b0000_0100,
        PH_LIT_HI  = 8'b0000_1000,
        PH_LITERAL = 8'b0001_0000,
        PH_CPY_LO  = 8'b0010_0000,
        PH_CPY_HI  = 8'b0100_0000,
        PH_COPY    = 8'b1000_0000
    } phase_t;

    // Request handed from the parser to the history stage.
    typedef struct packed {
        logic        valid;
        logic        is_copy;   // pixel comes from the ring
        logic        src_ok;    // source lies at or after the first pixel
        logic [23:0] lit_pixel; // literal pixel or forced zero
        logic [1:0]  status;
        logic        last;
    } hist_req_t;

endpackage

FILE: rtl/core/rgblz_history.sv
// ----------------------------------------------------------------------------
// rgblz_history: history ring with registered read and write-back
// Reads the copy source, selects forwarded data, writes the pixel back.
// ----------------------------------------------------------------------------
module rgblz_history
    import rgblz_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    localparam int AW = $clog2(HISTORY_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,      // stage 1 advances into stage 2
    input  hist_req_t     req,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    output hist_req_t     s2_req,
    output logic [23:0]   s2_pixel,
    input  logic          s2_take   // stage 2 moves to the output
);

    logic [23:0]   ring [HISTORY_DEPTH];
    logic [23:0]   rd_data_reg;
    hist_req_t     s2_reg;
    logic [AW-1:0] s2_wr_reg;
    logic          fwd_reg;
    logic [23:0]   fwd_data_reg;
    logic [23:0]   px;

    // A copy with distance 1 reads the pixel still held in stage 2.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_data_reg <= ring[rd_addr];
        end
        if (s2_take && s2_reg.valid && s2_reg.status != ST_STOP)
        begin
            ring[s2_wr_reg] <= px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s2_reg <= req;
        end
        else if (s2_take)
        begin
            s2_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_wr_reg    <= wr_addr;
            fwd_reg      <= s2_reg.valid && s2_reg.status != ST_STOP && s2_wr_reg == rd_addr;
            fwd_data_reg <= px;
        end
    end

    always_comb
    begin
        if (!s2_reg.is_copy || !s2_reg.src_ok)
        begin
            px = s2_reg.lit_pixel;
        end
        else if (fwd_reg)
        begin
            px = fwd_data_reg;
        end
        else
        begin
            px = rd_data_reg;
        end
    end

    assign s2_req   = s2_reg;
    assign s2_pixel = px;

endmodule

FILE: rtl/core/rgb_pixel_lz_decoder.sv
// ----------------------------------------------------------------------------
// rgb_pixel_lz_decoder: streaming LZ decoder for 24-bit RGB images
// Parses compressed bytes, replays copies from a history ring, emits pixels.
// ----------------------------------------------------------------------------
//  channel  | signals                         | role
//  ---------+---------------------------------+---------------------------
//  in       | in_valid in_ready mode data_byte| byte or drain tick beats
//  out      | out_valid out_ready pixel       | one pixel beat per result
//           | last_pixel status               |
//  apb      | psel penable pwrite paddr ...   | register writes and reads
//
// One beat per cycle sustained. Parser state sits in flops; a pixel beat
// passes a history stage (synchronous ring read, write-back with
// forwarding of the previous pixel) and then the output register.
// The ring is undefined after reset; no clearing pass is needed.
// in_ready drops only while the history stage and output register are full
// and the output side stalls.
// ----------------------------------------------------------------------------
module rgb_pixel_lz_decoder
    import rgblz_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] pixel,
    output logic        last_pixel,
    output logic [1:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

    // configuration
    logic [10:0] width_reg;
    logic [23:0] count_reg;
    logic [23:0] clen_reg;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd4;
            count_reg <= 24'd1;
            clen_reg  <= 24'd3;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_WIDTH: width_reg <= pwdata[10:0];
                REG_COUNT: count_reg <= pwdata[23:0];
                REG_CLEN:  clen_reg  <= pwdata[23:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH: prdata = {21'd0, width_reg};
            REG_COUNT: prdata = {8'd0, count_reg};
            REG_CLEN:  prdata = {8'd0, clen_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // effective values
    logic [12:0] w_eff;
    logic [23:0] cnt_eff;
    logic [23:0] clen_eff;

    always_comb
    begin
        if (width_reg < 11'd4)
            w_eff = 13'd4;
        else if ({2'd0, width_reg} > MAXW)
            w_eff = MAXW;
        else
            w_eff = {2'd0, width_reg};
        cnt_eff  = (count_reg == 24'd0) ? 24'd1 : count_reg;
        clen_eff = (clen_reg < 24'd3) ? 24'd3 : clen_reg;
    end

    // parser state
    phase_t      phase_reg,   phase_next;
    logic [23:0] pout_reg,    pout_next;
    logic [23:0] bin_reg,     bin_next;
    logic [15:0] part_reg,    part_next;
    logic [1:0]  bip_reg,     bip_next;
    logic [16:0] run_reg,     run_next;
    logic [4:0]  sel_reg,     sel_next;
    logic [7:0]  low_reg,     low_next;
    logic        halt_reg,    halt_next;

    // back distance from the current selector
    logic [15:0] back_d;
    logic [15:0] w16;

    assign w16 = {3'd0, w_eff};

    always_comb
    begin
        if (sel_reg < 5'd6)
            back_d = 16'(sel_reg) + 16'd1;
        else if (sel_reg < 5'd13)
            back_d = w16 - 16'd3 + 16'(sel_reg - 5'd6);
        else if (sel_reg < 5'd20)
            back_d = (w16 << 1) - 16'd3 + 16'(sel_reg - 5'd13);
        else if (sel_reg < 5'd27)
            back_d = (w16 << 1) + w16 - 16'd3 + 16'(sel_reg - 5'd20);
        else
            back_d = (w16 << 2) - 16'd2 + 16'(sel_reg - 5'd27);
    end

    // pipeline handshake
    hist_req_t   req;
    hist_req_t   s2_req;
    logic [23:0] s2_pixel;
    logic        out_valid_reg;
    logic        s2_take;
    logic        adv;
    logic        accept;

    assign s2_take  = s2_req.valid && (!out_valid_reg || out_ready);
    assign adv      = !s2_req.valid || s2_take;
    assign in_ready = adv;
    assign accept   = in_valid && in_ready;

    // literal bounds
    logic [16:0] n_lit;
    logic        lit_bad;
    logic        lit_start;
    logic [26:0] need_bytes;
    logic [24:0] need_pix;
    logic [23:0] bin_inc;

    assign bin_inc    = bin_reg + 24'd1;
    assign need_bytes = 27'(bin_inc) + 27'(n_lit) * 27'd3;
    assign need_pix   = 25'(pout_reg) + 25'(n_lit);
    assign lit_bad    = need_bytes > 27'(clen_eff) || need_pix > 25'(cnt_eff);

    logic [23:0] gpx;
    assign gpx = {data_byte, part_reg};

    always_comb
    begin
        phase_next = phase_reg;
        pout_next  = pout_reg;
        bin_next   = bin_reg;
        part_next  = part_reg;
        bip_next   = bip_reg;
        run_next   = run_reg;
        sel_next   = sel_reg;
        low_next   = low_reg;
        halt_next  = halt_reg;
        n_lit      = 17'(data_byte) + 17'd1;
        lit_start  = 1'b0;
        req        = '0;

        if (phase_reg == PH_LIT_HI)
            n_lit = {1'b0, data_byte, low_reg} + LIT_EXT_BASE;

        if (accept && !halt_reg)
        begin
            if (mode)
            begin
                if (phase_reg == PH_COPY)
                begin
                    if (pout_reg >= cnt_eff)
                    begin
                        run_next   = '0;
                        phase_next = PH_CONTROL;
                    end
                    else
                    begin
                        req.valid   = 1'b1;
                        req.is_copy = 1'b1;
                        req.src_ok  = 24'(back_d) <= pout_reg;
                        req.status  = req.src_ok ? ST_OK : ST_EARLY;
                        pout_next   = pout_reg + 24'd1;
                        req.last    = pout_next == cnt_eff;
                        if (run_reg != 17'd0)
                            run_next = run_reg - 17'd1;
                        if (run_next == 17'd0 || pout_next >= cnt_eff)
                        begin
                            run_next   = '0;
                            phase_next = PH_CONTROL;
                        end
                    end
                end
            end
            else
            begin
                priority case (1'b1)
                    phase_reg == PH_FIRST, phase_reg == PH_LITERAL:
                    begin
                        bin_next = bin_inc;
                        if (bip_reg < 2'd2)
                        begin
                            if (bip_reg == 2'd0)
                                part_next = {part_reg[15:8], data_byte};
                            else
                                part_next = {data_byte, part_reg[7:0]};
                            bip_next = bip_reg + 2'd1;
                        end
                        else
                        begin
                            part_next     = '0;
                            bip_next      = '0;
                            req.valid     = 1'b1;
                            req.lit_pixel = gpx;
                            req.status    = ST_OK;
                            pout_next     = pout_reg + 24'd1;
                            req.last      = pout_next == cnt_eff;
                            if (phase_reg == PH_FIRST)
                                phase_next = PH_CONTROL;
                            else
                            begin
                                if (run_reg != 17'd0)
                                    run_next = run_reg - 17'd1;
                                if (run_next == 17'd0)
                                    phase_next = PH_CONTROL;
                            end
                        end
                    end
                    phase_reg == PH_CONTROL:
                    begin
                        if (bin_reg < clen_eff)
                        begin
                            bin_next = bin_inc;
                            if ((data_byte & COPY_FLAG) == 8'd0)
                            begin
                                if (data_byte != LIT_EXT_CODE)
                                    lit_start = 1'b1;
                                else if (bin_inc >= clen_eff - 24'd1)
                                    halt_next = 1'b1;
                                else
                                    phase_next = PH_LIT_LO;
                            end
                            else
                            begin
                                sel_next = data_byte[6:2] & SEL_MASK;
                                if (data_byte[1:0] != 2'd3)
                                begin
                                    if (pout_reg >= cnt_eff)
                                    begin
                                        run_next   = '0;
                                        phase_next = PH_CONTROL;
                                    end
                                    else
                                    begin
                                        run_next   = 17'(data_byte[1:0]) + 17'd1;
                                        phase_next = PH_COPY;
                                    end
                                end
                                else if (bin_inc >= clen_eff - 24'd1)
                                    halt_next = 1'b1;
                                else
                                    phase_next = PH_CPY_LO;
                            end
                        end
                    end
                    phase_reg == PH_LIT_LO, phase_reg == PH_CPY_LO:
                    begin
                        bin_next   = bin_inc;
                        low_next   = data_byte;
                        phase_next = (phase_reg == PH_LIT_LO) ? PH_LIT_HI : PH_CPY_HI;
                    end
                    phase_reg == PH_LIT_HI:
                    begin
                        bin_next  = bin_inc;
                        lit_start = 1'b1;
                    end
                    phase_reg == PH_CPY_HI:
                    begin
                        bin_next = bin_inc;
                        if (pout_reg >= cnt_eff)
                        begin
                            run_next   = '0;
                            phase_next = PH_CONTROL;
                        end
                        else
                        begin
                            run_next   = {1'b0, data_byte, low_reg} + CPY_EXT_BASE;
                            phase_next = PH_COPY;
                        end
                    end
                    default: ;
                endcase

                if (lit_start)
                begin
                    if (lit_bad)
                        halt_next = 1'b1;
                    else
                    begin
                        run_next   = n_lit;
                        bip_next   = '0;
                        part_next  = '0;
                        phase_next = PH_LITERAL;
                    end
                end

                if (halt_next)
                begin
                    run_next   = '0;
                    req        = '0;
                    req.valid  = 1'b1;
                    req.status = ST_STOP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            pout_reg  <= '0;
            bin_reg   <= '0;
            part_reg  <= '0;
            bip_reg   <= '0;
            run_reg   <= '0;
            sel_reg   <= '0;
            low_reg   <= '0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pout_reg  <= pout_next;
            bin_reg   <= bin_next;
            part_reg  <= part_next;
            bip_reg   <= bip_next;
            run_reg   <= run_next;
            sel_reg   <= sel_next;
            low_reg   <= low_next;
            halt_reg  <= halt_next;
        end
    end

    // ring addresses: write slot is pixels_out, source slot is pixels_out - d
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_addr = pout_reg[AW-1:0];
    assign rd_addr = AW'(pout_reg) - AW'(back_d);

    rgblz_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .req      (req),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .s2_req   (s2_req),
        .s2_pixel (s2_pixel),
        .s2_take  (s2_take)
    );

    // output register
    logic [23:0] pixel_reg;
    logic        last_reg;
    logic [1:0]  status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_take)
        begin
            pixel_reg  <= s2_pixel;
            last_reg   <= s2_req.last;
            status_reg <= s2_req.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel      = pixel_reg;
    assign last_pixel = last_reg;
    assign status     = status_reg;

endmodule
